// ===== hw/rtl/grmcs_pkg.sv =====
// shared types, constants and shading tables for the grid ray march column shader
`default_nettype none

package grmcs_pkg;

  localparam int MAX_STEPS     = 160;
  localparam int MAP_SIZE      = 16;
  localparam int SCREEN_HEIGHT = 720;

  localparam int HALF_HEIGHT = SCREEN_HEIGHT / 2;

  localparam int K_W       = $clog2(MAX_STEPS + 1);
  localparam int CAM_W     = 16;
  localparam int DIR_W     = 16;
  localparam int STEP_W    = 12;
  localparam int DIR_FRAC  = 14;
  localparam int CELL_FRAC = 12;
  localparam int INC_W     = DIR_W + STEP_W + 1;
  localparam int OFF_W     = INC_W + K_W;
  localparam int PX_W      = OFF_W - DIR_FRAC + 1;
  localparam int CELL_W    = PX_W - 1 - CELL_FRAC;
  localparam int MAP_IDX_W = 4;
  localparam int MAP_BITS  = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WALL_WORD_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_ROWS_0_TO_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_ROWS_4_TO_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_ROWS_8_TO_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_ROWS_12_TO_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH        = 3'd4;

  localparam logic [STEP_W-1:0] STEP_LENGTH_RESET = 12'd410;

  typedef enum logic [1:0] {
    CAUSE_LIMIT = 2'd0,
    CAUSE_WALL  = 2'd1,
    CAUSE_LEFT  = 2'd2
  } cause_t;

  typedef logic [7:0] lut8_t [0:MAX_STEPS];
  typedef logic [9:0] lut10_t [0:MAX_STEPS];

  function automatic lut8_t bright_lut();
    lut8_t t;
    for (int i = 0; i <= MAX_STEPS; i++) begin
      t[i] = 8'((255 * i) / MAX_STEPS);
    end
    return t;
  endfunction

  function automatic lut10_t top_lut();
    lut10_t t;
    for (int i = 0; i <= MAX_STEPS; i++) begin
      t[i] = 10'((5 * HALF_HEIGHT * MAX_STEPS - 6 * HALF_HEIGHT * i) / (5 * MAX_STEPS));
    end
    return t;
  endfunction

  function automatic lut10_t height_lut();
    lut10_t t;
    for (int i = 0; i <= MAX_STEPS; i++) begin
      t[i] = 10'((12 * HALF_HEIGHT * i) / (5 * MAX_STEPS));
    end
    return t;
  endfunction

  localparam lut8_t  BRIGHT_TABLE = bright_lut();
  localparam lut10_t TOP_TABLE    = top_lut();
  localparam lut10_t HEIGHT_TABLE = height_lut();

endpackage

`default_nettype wire

// ===== hw/rtl/grid_ray_march_column_shader.sv =====
// top level: fixed step ray march over a 16x16 wall bitmap and column shading
// sequence: the ray is loaded on start, then one march step per sample (1 to MAX_STEPS = 160
// samples), then a shading step, then done strobes with the result
// throughput: one ray at a time, set by the single step accumulator; busy stays high
// until done, and a new start is taken in the cycle done is shown
// reset: rst (synchronous) clears the wall bitmap, loads step_length 410, goes idle
`default_nettype none

module grid_ray_march_column_shader import grmcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [CAM_W-1:0]       camera_x,
  input  logic [CAM_W-1:0]       camera_y,
  input  logic signed [DIR_W-1:0] ray_dx,
  input  logic signed [DIR_W-1:0] ray_dy,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [7:0]             step_count,
  output logic [1:0]             stop_cause,
  output logic [7:0]             brightness,
  output logic signed [9:0]      strip_top,
  output logic [9:0]             strip_height
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MARCH = 3'b010,
    ST_SHADE = 3'b100
  } state_t;

  state_t                   state;
  logic [MAP_BITS-1:0]      wall_map;
  logic [STEP_W-1:0]        step_len;
  logic [CAM_W-1:0]         cam_x;
  logic [CAM_W-1:0]         cam_y;
  logic signed [INC_W-1:0]  inc_x;
  logic signed [INC_W-1:0]  inc_y;
  logic signed [OFF_W-1:0]  off_x;
  logic signed [OFF_W-1:0]  off_y;
  logic [K_W-1:0]           k;
  logic [K_W-1:0]           steps;
  cause_t                   cause;

  logic signed [INC_W-1:0]  prod_x;
  logic signed [INC_W-1:0]  prod_y;
  logic signed [PX_W-1:0]   pos_x;
  logic signed [PX_W-1:0]   pos_y;
  logic                     out_x;
  logic                     out_y;
  logic                     wall_hit;
  logic [K_W-1:0]           rem;

  // per step increment, exact
  assign prod_x = INC_W'(ray_dx) * INC_W'($signed({1'b0, step_len}));
  assign prod_y = INC_W'(ray_dy) * INC_W'($signed({1'b0, step_len}));

  // sample position: floor offset to Q.12, add camera
  assign pos_x = PX_W'($signed({1'b0, cam_x})) + PX_W'(off_x >>> DIR_FRAC);
  assign pos_y = PX_W'($signed({1'b0, cam_y})) + PX_W'(off_y >>> DIR_FRAC);

  assign out_x = pos_x[PX_W-1] | (pos_x[PX_W-2:CELL_FRAC] >= CELL_W'(MAP_SIZE));
  assign out_y = pos_y[PX_W-1] | (pos_y[PX_W-2:CELL_FRAC] >= CELL_W'(MAP_SIZE));

  assign wall_hit = wall_map[{pos_y[CELL_FRAC+MAP_IDX_W-1:CELL_FRAC],
                              pos_x[CELL_FRAC+MAP_IDX_W-1:CELL_FRAC]}];

  assign rem  = K_W'(MAX_STEPS) - steps;
  assign busy = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map <= '0;
      step_len <= STEP_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WALL_ROWS_0_TO_3:   wall_map[0*WALL_WORD_W +: WALL_WORD_W] <= cfg_data;
        REG_WALL_ROWS_4_TO_7:   wall_map[1*WALL_WORD_W +: WALL_WORD_W] <= cfg_data;
        REG_WALL_ROWS_8_TO_11:  wall_map[2*WALL_WORD_W +: WALL_WORD_W] <= cfg_data;
        REG_WALL_ROWS_12_TO_15: wall_map[3*WALL_WORD_W +: WALL_WORD_W] <= cfg_data;
        REG_STEP_LENGTH:        step_len <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_SHADE);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MARCH;
          end
        end
        ST_MARCH: begin
          if (out_x || out_y || wall_hit || (k == K_W'(MAX_STEPS))) begin
            state <= ST_SHADE;
          end
        end
        ST_SHADE: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cam_x <= camera_x;
          cam_y <= camera_y;
          inc_x <= prod_x;
          inc_y <= prod_y;
          off_x <= OFF_W'(prod_x);
          off_y <= OFF_W'(prod_y);
          k     <= K_W'(1);
        end
      end
      ST_MARCH: begin
        priority if (out_x || out_y) begin
          steps <= K_W'(MAX_STEPS);
          cause <= CAUSE_LEFT;
        end else if (wall_hit) begin
          steps <= k;
          cause <= CAUSE_WALL;
        end else if (k == K_W'(MAX_STEPS)) begin
          steps <= K_W'(MAX_STEPS);
          cause <= CAUSE_LIMIT;
        end else begin
          off_x <= off_x + OFF_W'(inc_x);
          off_y <= off_y + OFF_W'(inc_y);
          k     <= k + K_W'(1);
        end
      end
      ST_SHADE: begin
        step_count   <= 8'(steps);
        stop_cause   <= cause;
        brightness   <= BRIGHT_TABLE[rem];
        strip_top    <= TOP_TABLE[rem];
        strip_height <= HEIGHT_TABLE[rem];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grmcs_checker.sv =====
// port level checker for the grid ray march column shader, bound to the top level
`default_nettype none

module grmcs_checker import grmcs_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [7:0]              step_count,
  input logic [1:0]              stop_cause,
  input logic [7:0]              brightness,
  input logic [9:0]              strip_height
);

  // a result transaction always ends the busy period
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted start always makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start taken but not busy");

  // no two results back to back
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done repeated");

  // leaving the map or hitting the limit reports full distance and no strip
  assert property (@(posedge clk) disable iff (rst)
    (done && (stop_cause == CAUSE_LEFT || stop_cause == CAUSE_LIMIT)) |->
      (step_count == 8'(MAX_STEPS) && brightness == 8'd0 && strip_height == 10'd0))
    else $error("bad full distance result");

  // a result is only shown after a busy period
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without work");

endmodule

bind grid_ray_march_column_shader grmcs_checker u_grmcs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .step_count   (step_count),
  .stop_cause   (stop_cause),
  .brightness   (brightness),
  .strip_height (strip_height)
);

`default_nettype wire

// ===== sim/grid_ray_march_column_shader_tb.sv =====
// self-checking testbench for the grid ray march column shader: directed rays, then random phases
`timescale 1ns / 100ps

module grid_ray_march_column_shader_tb;
  import grmcs_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int LIMIT_NS = 20_000_000;
  localparam int TAIL_CYCLES = 2 * MAX_STEPS;
  localparam int N_PHASES = 12;
  localparam int RAYS_PER_PHASE = 115;
  localparam int N_DIRECTED = 23;
  localparam real TWO_PI = 6.283185307179586;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = REG_STEP_LENGTH + 1'b1;
  localparam logic [CFG_IDX_W-1:0] WALL_REGS [4] = '{REG_WALL_ROWS_0_TO_3,
    REG_WALL_ROWS_4_TO_7, REG_WALL_ROWS_8_TO_11, REG_WALL_ROWS_12_TO_15};

  typedef struct packed {
    logic [CAM_W-1:0]        cam_x;
    logic [CAM_W-1:0]        cam_y;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } ray_t;

  typedef struct packed {
    logic [7:0]        steps;
    cause_t            cause;
    logic [7:0]        bright;
    logic signed [9:0] top;
    logic [9:0]        height;
  } shade_t;

  typedef struct packed {
    logic [WALL_WORD_W-1:0] walls;
    logic [STEP_W-1:0]      stride;
    ray_t                   ray;
    logic                   typed;
    shade_t                 res;
  } probe_row_t;

  localparam shade_t NO_SHADE = '0;
  localparam shade_t LEFT_SHADE = '{8'd160, CAUSE_LEFT, 8'd0, 10'sd360, 10'd0};
  localparam shade_t LIMIT_SHADE = '{8'd160, CAUSE_LIMIT, 8'd0, 10'sd360, 10'd0};
  localparam shade_t LAST_WALL_SHADE = '{8'd160, CAUSE_WALL, 8'd0, 10'sd360, 10'd0};
  localparam shade_t FIRST_WALL_SHADE = '{8'd1, CAUSE_WALL, 8'd253, -10'sd69, 10'd858};

  localparam logic [WALL_WORD_W-1:0] NO_WALLS = '0;
  localparam logic [WALL_WORD_W-1:0] ALL_WALLS = '1;

  localparam logic [3:0][WALL_WORD_W-1:0] ROOM_WALLS = {
    {16'hFFFF, 16'h8001, 16'h8001, 16'h8001},
    {4{16'h8001}},
    {4{16'h8001}},
    {16'h8001, 16'h8001, 16'h8001, 16'hFFFF}
  };

  localparam logic signed [DIR_W-1:0] DIR_EXTREMES [7] = '{16'sd0, 16'sd16384,
    -16'sd16384, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1};

  localparam int IDLE_PCT [3] = '{0, 58, 32};

  localparam probe_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{NO_WALLS, 12'd410, '{16'h0000, 16'h0000, 16'sd0, -16'sd16384}, 1'b1, LEFT_SHADE},
    '{NO_WALLS, 12'd410, '{16'h0000, 16'h0000, -16'sd16384, 16'sd0}, 1'b1, LEFT_SHADE},
    '{NO_WALLS, 12'd410, '{16'hFFFF, 16'hFFFF, 16'sd16384, 16'sd0}, 1'b1, LEFT_SHADE},
    '{NO_WALLS, 12'd410, '{16'hFFFF, 16'hFFFF, 16'sd0, 16'sd16384}, 1'b1, LEFT_SHADE},
    '{NO_WALLS, 12'd410, '{16'h8000, 16'h8000, 16'sd0, 16'sd0}, 1'b1, LIMIT_SHADE},
    '{NO_WALLS, 12'd410, '{16'h8000, 16'h8000, 16'sd16384, 16'sd0}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd410, '{16'h0000, 16'h0000, 16'sd16384, 16'sd16384}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd410, '{16'h8000, 16'h8000, 16'sh8000, 16'sh7FFF}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd410, '{16'h0000, 16'h0000, 16'sd11585, 16'sd11585}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd410, '{16'h1234, 16'hABCD, -16'sd1, 16'sd1}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd410, '{16'h5A5A, 16'hA5A5, -16'sd11585, -16'sd11585}, 1'b0, NO_SHADE},
    '{ALL_WALLS, 12'd410, '{16'h8000, 16'h8000, 16'sd16384, 16'sd0}, 1'b1, FIRST_WALL_SHADE},
    '{ALL_WALLS, 12'd410, '{16'h0000, 16'h0000, 16'sd0, -16'sd16384}, 1'b1, LEFT_SHADE},
    '{ALL_WALLS, 12'd410, '{16'h0000, 16'h0000, 16'sd0, 16'sd0}, 1'b1, FIRST_WALL_SHADE},
    '{ALL_WALLS, 12'd410, '{16'hFFFF, 16'h0000, 16'sh8000, 16'sh8000}, 1'b1, LEFT_SHADE},
    '{ALL_WALLS, 12'd0, '{16'h7FFF, 16'h7FFF, 16'sd16384, 16'sd16384}, 1'b1,
      FIRST_WALL_SHADE},
    '{NO_WALLS, 12'd0, '{16'h0000, 16'h0000, -16'sd16384, -16'sd16384}, 1'b1, LIMIT_SHADE},
    '{NO_WALLS, 12'hFFF, '{16'h8000, 16'h8000, 16'sd16384, 16'sd0}, 1'b1, LEFT_SHADE},
    '{NO_WALLS, 12'hFFF, '{16'h0000, 16'h0000, 16'sd0, 16'sd16384}, 1'b0, NO_SHADE},
    '{NO_WALLS, 12'd1, '{16'h0000, 16'h0000, 16'sd16384, 16'sd16384}, 1'b1, LIMIT_SHADE},
    '{NO_WALLS, 12'd1, '{16'h0000, 16'h0000, -16'sd16384, 16'sd0}, 1'b1, LEFT_SHADE},
    // floor toward minus infinity pushes a tiny negative offset out of the map
    '{NO_WALLS, 12'd1, '{16'h0000, 16'h0000, -16'sd1, 16'sd0}, 1'b1, LEFT_SHADE},
    // wall cell entered exactly at the last step
    '{64'h8000, 12'd384, '{16'h0000, 16'h0800, 16'sd16384, 16'sd0}, 1'b1, LAST_WALL_SHADE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CAM_W-1:0] camera_x = '0;
  logic [CAM_W-1:0] camera_y = '0;
  logic signed [DIR_W-1:0] ray_dx = '0;
  logic signed [DIR_W-1:0] ray_dy = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [7:0] step_count;
  logic [1:0] stop_cause;
  logic [7:0] brightness;
  logic signed [9:0] strip_top;
  logic [9:0] strip_height;

  logic [3:0][WALL_WORD_W-1:0] wall_shadow = '0;
  logic [STEP_W-1:0] stride_shadow = STEP_LENGTH_RESET;
  shade_t pending_shades [$];
  shade_t want;
  int mismatch_count = 0;

  grid_ray_march_column_shader DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .camera_x(camera_x),
    .camera_y(camera_y),
    .ray_dx(ray_dx),
    .ray_dy(ray_dy),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .step_count(step_count),
    .stop_cause(stop_cause),
    .brightness(brightness),
    .strip_top(strip_top),
    .strip_height(strip_height)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic shade_t predict_column_shade(input ray_t r);
    longint run, px, py, cx, cy;
    int steps, rem;
    cause_t cause;
    shade_t s;
    steps = MAX_STEPS;
    cause = CAUSE_LIMIT;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      run = k * longint'(stride_shadow);
      px = longint'(r.cam_x) + ((longint'(r.dx) * run) >>> DIR_FRAC);
      py = longint'(r.cam_y) + ((longint'(r.dy) * run) >>> DIR_FRAC);
      cx = px >>> CELL_FRAC;
      cy = py >>> CELL_FRAC;
      if (px < 0 || py < 0 || cx >= MAP_SIZE || cy >= MAP_SIZE) begin
        cause = CAUSE_LEFT;
        break;
      end
      if (wall_shadow[cy >> 2][cx + 16 * (cy & 3)]) begin
        steps = k;
        cause = CAUSE_WALL;
        break;
      end
    end
    rem = MAX_STEPS - steps;
    s.steps = 8'(steps);
    s.cause = cause;
    s.bright = 8'((255 * rem) / MAX_STEPS);
    s.top = 10'((5 * HALF_HEIGHT * MAX_STEPS - 6 * HALF_HEIGHT * rem) / (5 * MAX_STEPS));
    s.height = 10'((12 * HALF_HEIGHT * rem) / (5 * MAX_STEPS));
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
    mismatch_count++;
  endtask

  task automatic send_ray(input ray_t r, input logic typed, input shade_t res);
    start <= 1'b1;
    camera_x <= r.cam_x;
    camera_y <= r.cam_y;
    ray_dx <= r.dx;
    ray_dy <= r.dy;
    do @(posedge clk); while (busy);
    pending_shades.push_back(typed ? res : predict_column_shade(r));
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [3:0][WALL_WORD_W-1:0] words,
                             input logic [STEP_W-1:0] stride);
    logic [CFG_DATA_W-1:0] data;
    cfg_write <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= WALL_REGS[i];
      cfg_data <= words[i];
      @(posedge clk);
      wall_shadow[i] = words[i];
    end
    // upper bits of the step length write are don't care
    data = {$urandom, $urandom};
    data[STEP_W-1:0] = stride;
    cfg_index <= REG_STEP_LENGTH;
    cfg_data <= data;
    @(posedge clk);
    stride_shadow = stride;
    cfg_index <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FIRST_UNMAPPED));
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_shades.size() == 0) begin
        report_mismatch("result with no transaction pending", 1, 0);
      end else begin
        want = pending_shades.pop_front();
        if (step_count !== want.steps) report_mismatch("step_count", step_count, want.steps);
        if (stop_cause !== want.cause) report_mismatch("stop_cause", stop_cause, want.cause);
        if (brightness !== want.bright) report_mismatch("brightness", brightness, want.bright);
        if (strip_top !== want.top) report_mismatch("strip_top", strip_top, want.top);
        if (strip_height !== want.height) begin
          report_mismatch("strip_height", strip_height, want.height);
        end
      end
    end
  end

  initial begin
    logic [3:0][WALL_WORD_W-1:0] words;
    logic [STEP_W-1:0] stride;
    ray_t r;
    real ang;
    int pick;
    int gap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].walls !== wall_shadow[0] ||
          DIRECTED_ROWS[i].stride !== stride_shadow) begin
        hold_until_drained();
        load_config({4{DIRECTED_ROWS[i].walls}}, DIRECTED_ROWS[i].stride);
      end
      send_ray(DIRECTED_ROWS[i].ray, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      for (int i = 0; i < 4; i++) begin
        case (p % 4)
          0: words[i] = ROOM_WALLS[i] |
                        ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
          1: words[i] = {$urandom, $urandom} & {$urandom, $urandom};
          2: words[i] = ROOM_WALLS[i] | ({$urandom, $urandom} & {$urandom, $urandom});
          default: words[i] = (p == 3) ? ALL_WALLS : NO_WALLS;
        endcase
      end
      case (p)
        0: stride = STEP_LENGTH_RESET;
        1: stride = '1;
        2: stride = 12'd1;
        4: stride = '0;
        default: stride = $urandom_range(1) ? STEP_W'($urandom_range(4095, 1))
                                            : STEP_W'($urandom_range(600, 200));
      endcase
      hold_until_drained();
      load_config(words, stride);

      for (int n = 0; n < RAYS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        r.cam_x = CAM_W'($urandom);
        r.cam_y = CAM_W'($urandom);
        if (pick < 80) begin
          ang = $urandom_range(65535) * TWO_PI / 65536.0;
          r.dx = DIR_W'($rtoi(16384.0 * $sin(ang)));
          r.dy = DIR_W'($rtoi(16384.0 * $cos(ang)));
        end else if (pick < 90) begin
          r.dx = DIR_EXTREMES[$urandom_range(6)];
          r.dy = DIR_EXTREMES[$urandom_range(6)];
        end else begin
          r.dx = DIR_W'($urandom);
          r.dy = DIR_W'($urandom);
        end
        send_ray(r, 1'b0, NO_SHADE);
        if ($urandom_range(49) == 0) begin
          hold_until_drained();
        end else if ($urandom_range(99) < IDLE_PCT[p % 3]) begin
          start <= 1'b0;
          gap = ($urandom_range(3) == 0) ? $urandom_range(MAX_STEPS + 8) : $urandom_range(3);
          repeat (gap + 1) @(posedge clk);
        end
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_shades.size() == 0) begin
      $display("[grid_ray_march_column_shader] OK");
    end else begin
      $display("[grid_ray_march_column_shader] ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("[grid_ray_march_column_shader] ERROR");
    $finish;
  end

endmodule
